/* hdl/ptbq_pkg.sv */
// Package for the proximity-to-button qualifier.
// Holds shared constants, register indexes and the structs passed between modules.
// No dependencies.
`default_nettype none

package ptbq_pkg;

	localparam int CalibSamplesDefault = 10;
	localparam int QueueDepth = 2;

	localparam logic [15:0] ErrDist = 16'hFFFF;

	localparam logic [15:0] BoundaryReset = 16'd61604;
	localparam logic [15:0] HoldReset = 16'd600;
	localparam logic [15:0] LockoutReset = 16'd500;
	localparam logic [15:0] LeftMinReset = 16'd280;
	localparam logic [15:0] RightMinReset = 16'd190;

	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BOUNDARY = 3'd0,
		REG_HOLD = 3'd1,
		REG_LOCKOUT = 3'd2,
		REG_LEFT_MIN = 3'd3,
		REG_RIGHT_MIN = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] boundary_q16;
		logic [15:0] hold_ms;
		logic [15:0] lockout_ms;
		logic [15:0] left_min_far;
		logic [15:0] right_min_far;
	} cfg_t;

	typedef struct packed {
		logic channel;
		logic [15:0] distance_mm;
		logic [31:0] time_ms;
		logic is_err;
		logic below_min;
	} item_t;

	typedef struct packed {
		logic out_channel;
		logic skipped;
		logic release_first;
		logic click;
		logic press;
		logic reset_request;
		logic touched;
		logic button_held;
	} result_t;

endpackage

`default_nettype wire

/* hdl/ptbq_front.sv */
// Front stage: accepts input words and classifies each as sensor error or below minimum.
// Depends on ptbq_pkg.
`default_nettype none

module ptbq_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire ptbq_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic channel,
	input wire logic [15:0] distance_mm,
	input wire logic [31:0] time_ms,
	output logic push,
	output ptbq_pkg::item_t push_item,
	input wire logic q_full
);
	import ptbq_pkg::*;

	logic valid_s1;
	item_t item_s1;
	logic adv;
	logic [15:0] min_far;

	assign in_stall = valid_s1 && q_full;
	assign adv = !in_stall;
	assign push = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign min_far = channel ? cfg.right_min_far : cfg.left_min_far;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1.channel <= channel;
			item_s1.distance_mm <= distance_mm;
			item_s1.time_ms <= time_ms;
			item_s1.is_err <= (distance_mm == ErrDist);
			item_s1.below_min <= (distance_mm < min_far);
		end
	end

endmodule

`default_nettype wire

/* hdl/ptbq_queue.sv */
// Short register queue between the front and back stages.
// Depends on ptbq_pkg.
`default_nettype none

module ptbq_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ptbq_pkg::item_t push_item,
	output logic full,
	input wire logic pop,
	output logic empty,
	output ptbq_pkg::item_t pop_item
);
	import ptbq_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	item_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == CntW'(QueueDepth));
	assign empty = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* hdl/ptbq_back.sv */
// Back stage: holds calibration, touch, hold and lockout state and registers one result per word.
// Depends on ptbq_pkg.
`default_nettype none

module ptbq_back #(
	parameter int CALIB_SAMPLES = ptbq_pkg::CalibSamplesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ptbq_pkg::cfg_t cfg,
	input wire logic q_empty,
	input wire ptbq_pkg::item_t item,
	output logic pop,
	output logic out_valid,
	input wire logic out_stall,
	output ptbq_pkg::result_t result
);
	import ptbq_pkg::*;

	localparam int CntW = $clog2(CALIB_SAMPLES + 1);
	localparam int Shift = 24;
	localparam longint Recip = ((64'd1 << Shift) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;

	logic [CntW-1:0] calib_count_q [2];
	logic [19:0] calib_sum_q [2];
	logic [15:0] far_q [2];
	logic prev_touched_q [2];
	logic held_q [2];
	logic [31:0] entry_time_q [2];
	logic entry_valid_q [2];
	logic [31:0] lockout_end_q;
	logic lockout_active_q;
	logic out_valid_q;
	result_t result_q;

	logic ch;
	logic [31:0] lock_diff;
	logic lock_skip;
	logic calibrating;
	logic do_reset;
	logic do_calib;
	logic do_run;
	logic [31:0] far_prod;
	logic tch;
	logic [19:0] sum_next;
	logic [CntW-1:0] cnt_next;
	logic [44:0] div_prod;
	logic l_hold_base;
	logic [31:0] l_entry_time;
	logic l_press;
	logic r_click;
	logic rel;
	logic clk_out;
	logic press;
	logic held_after;

	assign pop = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result = result_q;

	always_comb begin
		ch = item.channel;
		lock_diff = lockout_end_q - item.time_ms;
		lock_skip = lockout_active_q && (lock_diff != '0) && !lock_diff[31];
		calibrating = calib_count_q[ch] < CntW'(CALIB_SAMPLES);
		do_reset = !lock_skip && (item.is_err || (calibrating && item.below_min));
		do_calib = !lock_skip && !do_reset && calibrating;
		do_run = !lock_skip && !do_reset && !calibrating;
		far_prod = 32'(far_q[ch]) * 32'(cfg.boundary_q16);
		tch = {item.distance_mm, 16'd0} < far_prod;
		sum_next = calib_sum_q[ch] + 20'(item.distance_mm);
		cnt_next = calib_count_q[ch] + 1'b1;
		div_prod = 45'(sum_next) * 45'(Recip);

		l_hold_base = held_q[0];
		l_entry_time = entry_time_q[0];
		rel = 1'b0;
		clk_out = 1'b0;
		press = 1'b0;
		l_press = 1'b0;
		r_click = 1'b0;
		if (!ch) begin
			if (tch) begin
				if (!entry_valid_q[0]) begin
					l_entry_time = item.time_ms;
					rel = held_q[0];
					l_hold_base = 1'b0;
					clk_out = 1'b1;
				end
				l_press = ((item.time_ms - l_entry_time) >= {16'd0, cfg.hold_ms}) && !l_hold_base;
				press = l_press;
				held_after = l_hold_base || l_press;
			end else begin
				rel = held_q[0];
				held_after = 1'b0;
			end
		end else begin
			r_click = tch && !prev_touched_q[1];
			if (r_click) begin
				rel = held_q[1];
				clk_out = 1'b1;
				held_after = 1'b0;
			end else begin
				held_after = held_q[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				calib_count_q[i] <= '0;
				calib_sum_q[i] <= '0;
				far_q[i] <= '0;
				prev_touched_q[i] <= 1'b0;
				held_q[i] <= 1'b0;
				entry_time_q[i] <= '0;
				entry_valid_q[i] <= 1'b0;
			end
			lockout_end_q <= '0;
			lockout_active_q <= 1'b0;
			out_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (lockout_active_q && !lock_skip && !do_reset && !(do_run && r_click)) begin
					lockout_active_q <= 1'b0;
				end
				result_q.out_channel <= ch;
				result_q.skipped <= lock_skip || do_calib;
				result_q.release_first <= do_run && rel;
				result_q.click <= do_run && clk_out;
				result_q.press <= do_run && press;
				result_q.reset_request <= do_reset;
				result_q.touched <= do_run && tch;
				if (do_reset) begin
					result_q.button_held <= 1'b0;
					for (int i = 0; i < 2; i++) begin
						calib_count_q[i] <= '0;
						calib_sum_q[i] <= '0;
						far_q[i] <= '0;
						prev_touched_q[i] <= 1'b0;
						held_q[i] <= 1'b0;
						entry_time_q[i] <= '0;
						entry_valid_q[i] <= 1'b0;
					end
					lockout_end_q <= '0;
					lockout_active_q <= 1'b0;
				end else if (do_calib) begin
					result_q.button_held <= held_q[ch];
					calib_sum_q[ch] <= sum_next;
					calib_count_q[ch] <= cnt_next;
					if (cnt_next == CntW'(CALIB_SAMPLES)) begin
						far_q[ch] <= div_prod[Shift+15:Shift];
					end
				end else if (do_run) begin
					result_q.button_held <= held_after;
					prev_touched_q[ch] <= tch;
					held_q[ch] <= held_after;
					if (!ch) begin
						entry_valid_q[0] <= tch;
						entry_time_q[0] <= l_entry_time;
					end else if (r_click) begin
						lockout_active_q <= 1'b1;
						lockout_end_q <= item.time_ms + {16'd0, cfg.lockout_ms};
					end
				end else begin
					result_q.button_held <= held_q[ch];
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/proximity_to_button_qualifier.sv */
// Proximity-to-button qualifier: front classifier, two-word queue, back state unit.
// A word passes through the front register, the queue and the result register before its result word is valid.
// Throughput is one word per cycle while out_stall is low; the multiply-compare in the back unit is combinational.
// Reset clears all calibration, touch and lockout state and loads the register defaults.
// Depends on ptbq_pkg, ptbq_front, ptbq_queue and ptbq_back.
`default_nettype none

module proximity_to_button_qualifier #(
	parameter int CALIB_SAMPLES = ptbq_pkg::CalibSamplesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [ptbq_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic channel,
	input wire logic [15:0] distance_mm,
	input wire logic [31:0] time_ms,
	output logic out_valid,
	input wire logic out_stall,
	output logic out_channel,
	output logic skipped,
	output logic release_first,
	output logic click,
	output logic press,
	output logic reset_request,
	output logic touched,
	output logic button_held
);
	import ptbq_pkg::*;

	cfg_t cfg_q;
	logic push;
	item_t push_item;
	logic q_full;
	logic q_empty;
	logic pop;
	item_t pop_item;
	result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boundary_q16 <= BoundaryReset;
			cfg_q.hold_ms <= HoldReset;
			cfg_q.lockout_ms <= LockoutReset;
			cfg_q.left_min_far <= LeftMinReset;
			cfg_q.right_min_far <= RightMinReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOUNDARY: begin
					cfg_q.boundary_q16 <= cfg_data;
				end
				REG_HOLD: begin
					cfg_q.hold_ms <= cfg_data;
				end
				REG_LOCKOUT: begin
					cfg_q.lockout_ms <= cfg_data;
				end
				REG_LEFT_MIN: begin
					cfg_q.left_min_far <= cfg_data;
				end
				REG_RIGHT_MIN: begin
					cfg_q.right_min_far <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	ptbq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel(channel),
		.distance_mm(distance_mm),
		.time_ms(time_ms),
		.push(push),
		.push_item(push_item),
		.q_full(q_full)
	);

	ptbq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.empty(q_empty),
		.pop_item(pop_item)
	);

	ptbq_back #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.item(pop_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result)
	);

	assign out_channel = result.out_channel;
	assign skipped = result.skipped;
	assign release_first = result.release_first;
	assign click = result.click;
	assign press = result.press;
	assign reset_request = result.reset_request;
	assign touched = result.touched;
	assign button_held = result.button_held;

endmodule

`default_nettype wire
